### rtl/core/mpbm_pkg.sv
// Package for the multi-pattern byte matcher: sizes, command and result
// structs, mode and result codes, sequencer states. No dependencies.
`timescale 1ns / 1ps
package mpbm_pkg;

  localparam int NODES   = 1024;
  localparam int SYMBOLS = 256;
  localparam int NODE_W  = $clog2(NODES);
  localparam int SYM_W   = $clog2(SYMBOLS);
  localparam int CNT_W   = NODE_W + 1;
  localparam int EDGE_W  = NODE_W + SYM_W;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SCAN   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_BUILD  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic       found;
    logic       table_full;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SWEEP,
    S_INS_RD,
    S_INS_CHK,
    S_INS_LINK,
    S_INS_END,
    S_SCAN_RD,
    S_SCAN_MK,
    S_SCAN_END,
    S_BLD_INIT,
    S_BLD_Q,
    S_BLD_U,
    S_BLD_UF,
    S_BLD_V,
    S_BLD_W,
    S_BLD_F,
    S_BLD_MV,
    S_BLD_MF,
    S_BLD_S
  } state_t;

endpackage

### rtl/core/mpbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/multi_pattern_byte_matcher_unit.sv
// Aho-Corasick byte matcher top level: sequencer over four RAMs
// (transition table, fail links, match marks, breadth-first queue).
// Depends on mpbm_pkg and mpbm_ram.
// Paced by one read port per RAM: an insert byte sweeps a new node's row when
// it allocates one and skips the lookup once the pattern has run out of nodes;
// clear sweeps the root row; build visits every symbol of each queued node.
// One item at a time; busy is high meanwhile.
// Reset: a sweep zeroes the root row with busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module multi_pattern_byte_matcher_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mpbm_pkg::cmd_t    cmd,
  output logic              done,
  output mpbm_pkg::result_t result
);

  mpbm_pkg::state_t state, state_next;
  mpbm_pkg::cmd_t   cur_cmd;

  logic [mpbm_pkg::NODE_W-1:0] cursor;
  logic [mpbm_pkg::CNT_W-1:0]  node_count;
  logic [mpbm_pkg::CNT_W-1:0]  head;
  logic [mpbm_pkg::CNT_W-1:0]  tail;
  logic [mpbm_pkg::NODE_W-1:0] row_node;
  logic [mpbm_pkg::NODE_W-1:0] u;
  logic [mpbm_pkg::NODE_W-1:0] uf;
  logic [mpbm_pkg::NODE_W-1:0] v;
  logic [mpbm_pkg::NODE_W-1:0] f;
  logic [mpbm_pkg::SYM_W-1:0]  sym_cnt;
  logic                        seen;
  logic                        overflow;
  logic                        mark_v;
  logic                        quiet;

  // RAM ports
  logic                        goto_we;
  logic [mpbm_pkg::EDGE_W-1:0] goto_waddr, goto_raddr;
  logic [mpbm_pkg::NODE_W-1:0] goto_wdata, goto_rdata;
  logic                        fail_we;
  logic [mpbm_pkg::NODE_W-1:0] fail_waddr, fail_raddr, fail_wdata, fail_rdata;
  logic                        mark_we;
  logic [mpbm_pkg::NODE_W-1:0] mark_waddr, mark_raddr;
  logic                        mark_wdata, mark_rdata;
  logic                        queue_we;
  logic [mpbm_pkg::NODE_W-1:0] queue_waddr, queue_raddr, queue_wdata, queue_rdata;

  logic [mpbm_pkg::SYM_W-1:0]  sym;
  logic [mpbm_pkg::NODE_W-1:0] f_calc;
  logic                        accept;

  assign sym    = cur_cmd.byte_value[mpbm_pkg::SYM_W-1:0];
  assign f_calc = (u == '0) ? '0 : goto_rdata;
  assign busy   = (state != mpbm_pkg::S_IDLE);
  assign accept = start && !busy;

  mpbm_ram #(.WIDTH(mpbm_pkg::NODE_W), .DEPTH(mpbm_pkg::NODES * mpbm_pkg::SYMBOLS)) u_goto (
    .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
    .raddr(goto_raddr), .rdata(goto_rdata)
  );
  mpbm_ram #(.WIDTH(mpbm_pkg::NODE_W), .DEPTH(mpbm_pkg::NODES)) u_fail (
    .clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
    .raddr(fail_raddr), .rdata(fail_rdata)
  );
  mpbm_ram #(.WIDTH(1), .DEPTH(mpbm_pkg::NODES)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );
  mpbm_ram #(.WIDTH(mpbm_pkg::NODE_W), .DEPTH(mpbm_pkg::NODES)) u_queue (
    .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
    .raddr(queue_raddr), .rdata(queue_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mpbm_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            mpbm_pkg::MODE_INSERT: state_next = overflow ? mpbm_pkg::S_INS_END
                                                         : mpbm_pkg::S_INS_RD;
            mpbm_pkg::MODE_BUILD:  state_next = mpbm_pkg::S_BLD_INIT;
            mpbm_pkg::MODE_SCAN:   state_next = mpbm_pkg::S_SCAN_RD;
            default:               state_next = mpbm_pkg::S_SWEEP;
          endcase
        end
      end
      mpbm_pkg::S_SWEEP: begin
        if (sym_cnt == mpbm_pkg::SYM_W'(mpbm_pkg::SYMBOLS - 1)) begin
          if (!quiet && cur_cmd.mode == mpbm_pkg::MODE_INSERT) begin
            state_next = mpbm_pkg::S_INS_LINK;
          end else begin
            state_next = mpbm_pkg::S_IDLE;
          end
        end
      end
      mpbm_pkg::S_INS_RD:  state_next = mpbm_pkg::S_INS_CHK;
      mpbm_pkg::S_INS_CHK: begin
        if (goto_rdata == '0 && node_count + 1'b1 < mpbm_pkg::CNT_W'(mpbm_pkg::NODES)) begin
          state_next = mpbm_pkg::S_SWEEP;
        end else begin
          state_next = mpbm_pkg::S_INS_END;
        end
      end
      mpbm_pkg::S_INS_LINK: state_next = mpbm_pkg::S_INS_END;
      mpbm_pkg::S_INS_END:  state_next = mpbm_pkg::S_IDLE;
      mpbm_pkg::S_SCAN_RD:  state_next = mpbm_pkg::S_SCAN_MK;
      mpbm_pkg::S_SCAN_MK:  state_next = mpbm_pkg::S_SCAN_END;
      mpbm_pkg::S_SCAN_END: state_next = mpbm_pkg::S_IDLE;
      mpbm_pkg::S_BLD_INIT: state_next = mpbm_pkg::S_BLD_Q;
      mpbm_pkg::S_BLD_Q:    state_next = (head < tail) ? mpbm_pkg::S_BLD_U : mpbm_pkg::S_IDLE;
      mpbm_pkg::S_BLD_U:    state_next = mpbm_pkg::S_BLD_UF;
      mpbm_pkg::S_BLD_UF:   state_next = mpbm_pkg::S_BLD_V;
      mpbm_pkg::S_BLD_V:    state_next = mpbm_pkg::S_BLD_W;
      mpbm_pkg::S_BLD_W:    state_next = mpbm_pkg::S_BLD_F;
      mpbm_pkg::S_BLD_F:    state_next = (v != '0) ? mpbm_pkg::S_BLD_MV
                                                   : mpbm_pkg::S_BLD_S;
      mpbm_pkg::S_BLD_MV:   state_next = mpbm_pkg::S_BLD_MF;
      mpbm_pkg::S_BLD_MF:   state_next = mpbm_pkg::S_BLD_S;
      mpbm_pkg::S_BLD_S: begin
        state_next = (sym_cnt == mpbm_pkg::SYM_W'(mpbm_pkg::SYMBOLS - 1)) ? mpbm_pkg::S_BLD_Q
                                                                         : mpbm_pkg::S_BLD_V;
      end
      default: state_next = mpbm_pkg::S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    goto_we     = 1'b0;
    goto_waddr  = {row_node, sym_cnt};
    goto_wdata  = '0;
    goto_raddr  = {cursor, sym};
    fail_we     = 1'b0;
    fail_waddr  = row_node;
    fail_wdata  = '0;
    fail_raddr  = queue_rdata;
    mark_we     = 1'b0;
    mark_waddr  = row_node;
    mark_wdata  = 1'b0;
    mark_raddr  = goto_rdata;
    queue_we    = 1'b0;
    queue_waddr = tail[mpbm_pkg::NODE_W-1:0];
    queue_wdata = v;
    queue_raddr = head[mpbm_pkg::NODE_W-1:0];
    case (state)
      mpbm_pkg::S_SWEEP: begin
        goto_we = 1'b1;
        fail_we = (sym_cnt == '0);
        mark_we = (sym_cnt == '0);
      end
      mpbm_pkg::S_INS_LINK: begin
        goto_we    = 1'b1;
        goto_waddr = {cursor, sym};
        goto_wdata = row_node;
      end
      mpbm_pkg::S_INS_END: begin
        mark_we    = cur_cmd.last && !overflow;
        mark_waddr = cursor;
        mark_wdata = 1'b1;
      end
      mpbm_pkg::S_BLD_INIT: begin
        queue_we    = 1'b1;
        queue_waddr = '0;
        queue_wdata = '0;
      end
      mpbm_pkg::S_BLD_V: goto_raddr = {u, sym_cnt};
      mpbm_pkg::S_BLD_W: goto_raddr = {uf, sym_cnt};
      mpbm_pkg::S_BLD_F: begin
        if (v != '0) begin
          fail_we    = 1'b1;
          fail_waddr = v;
          fail_wdata = f_calc;
          mark_raddr = v;
        end else begin
          goto_we    = 1'b1;
          goto_waddr = {u, sym_cnt};
          goto_wdata = f_calc;
        end
      end
      mpbm_pkg::S_BLD_MV: mark_raddr = f;
      mpbm_pkg::S_BLD_MF: begin
        mark_we    = 1'b1;
        mark_waddr = v;
        mark_wdata = mark_v | mark_rdata;
        queue_we   = (tail < mpbm_pkg::CNT_W'(mpbm_pkg::NODES));
      end
      default: ;
    endcase
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mpbm_pkg::S_SWEEP;
      quiet      <= 1'b1;
      row_node   <= '0;
      sym_cnt    <= '0;
      node_count <= '0;
      cursor     <= '0;
      seen       <= 1'b0;
      overflow   <= 1'b0;
      done       <= 1'b0;
      head       <= '0;
      tail       <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        mpbm_pkg::S_IDLE: begin
          if (accept) begin
            cur_cmd  <= cmd;
            quiet    <= 1'b0;
            row_node <= '0;
            sym_cnt  <= '0;
          end
        end
        mpbm_pkg::S_SWEEP: begin
          sym_cnt <= sym_cnt + 1'b1;
          if (state_next == mpbm_pkg::S_IDLE && !quiet) begin
            // clear finished
            node_count         <= '0;
            cursor             <= '0;
            seen               <= 1'b0;
            overflow           <= 1'b0;
            done               <= 1'b1;
            result.result_kind <= mpbm_pkg::KIND_CLEAR;
            result.found       <= 1'b0;
            result.table_full  <= 1'b0;
          end
        end
        mpbm_pkg::S_INS_CHK: begin
          if (goto_rdata != '0) begin
            cursor <= goto_rdata;
          end else if (state_next == mpbm_pkg::S_SWEEP) begin
            node_count <= node_count + 1'b1;
            row_node   <= mpbm_pkg::NODE_W'(node_count + 1'b1);
            sym_cnt    <= '0;
          end else begin
            overflow <= 1'b1;
          end
        end
        mpbm_pkg::S_INS_LINK: cursor <= row_node;
        mpbm_pkg::S_INS_END: begin
          if (cur_cmd.last) begin
            cursor             <= '0;
            overflow           <= 1'b0;
            done               <= 1'b1;
            result.result_kind <= mpbm_pkg::KIND_INSERT;
            result.found       <= 1'b0;
            result.table_full  <= overflow;
          end
        end
        mpbm_pkg::S_SCAN_MK: cursor <= goto_rdata;
        mpbm_pkg::S_SCAN_END: begin
          if (cur_cmd.last) begin
            cursor             <= '0;
            seen               <= 1'b0;
            done               <= 1'b1;
            result.result_kind <= mpbm_pkg::KIND_SCAN;
            result.found       <= seen | mark_rdata;
            result.table_full  <= 1'b0;
          end else if (mark_rdata) begin
            seen <= 1'b1;
          end
        end
        mpbm_pkg::S_BLD_INIT: begin
          head <= '0;
          tail <= mpbm_pkg::CNT_W'(1);
        end
        mpbm_pkg::S_BLD_Q: begin
          if (head < tail) begin
            head <= head + 1'b1;
          end else begin
            cursor             <= '0;
            seen               <= 1'b0;
            overflow           <= 1'b0;
            done               <= 1'b1;
            result.result_kind <= mpbm_pkg::KIND_BUILD;
            result.found       <= 1'b0;
            result.table_full  <= 1'b0;
          end
        end
        mpbm_pkg::S_BLD_U: u <= queue_rdata;
        mpbm_pkg::S_BLD_UF: begin
          uf      <= fail_rdata;
          sym_cnt <= '0;
        end
        mpbm_pkg::S_BLD_W: v <= goto_rdata;
        mpbm_pkg::S_BLD_F: f <= f_calc;
        mpbm_pkg::S_BLD_MV: mark_v <= mark_rdata;
        mpbm_pkg::S_BLD_MF: begin
          if (tail < mpbm_pkg::CNT_W'(mpbm_pkg::NODES)) begin
            tail <= tail + 1'b1;
          end
        end
        mpbm_pkg::S_BLD_S: sym_cnt <= sym_cnt + 1'b1;
        default: ;
      endcase
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");
  a_found_scan: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.result_kind == mpbm_pkg::KIND_SCAN))
    else $error("found set on a non-scan result");
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (result.result_kind == mpbm_pkg::KIND_INSERT))
    else $error("table_full set on a non-insert result");
  a_node_range: assert property (@(posedge clk) disable iff (rst)
    node_count < mpbm_pkg::CNT_W'(mpbm_pkg::NODES))
    else $error("node count beyond table");
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == mpbm_pkg::S_BLD_U) |-> (head <= tail))
    else $error("queue head passed tail");

endmodule
